// ----- sv/vpc_pkg.sv -----
// Package for the volume pot controller: command and register codes, controller states,
// the controller/datapath interface structs and the volume-to-wiper curve.
// No dependencies.
package vpc_pkg;

   localparam int CURVE_ENTRIES = 21;
   localparam int IDX_W         = 5;
   localparam int VOL_W         = 7;
   localparam int POT_W         = 8;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 8;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 40;
   localparam int RSP_USER_W    = 2;

   localparam logic [VOL_W-1:0] VOL_LIMIT  = 7'd100;
   localparam logic [POT_W-1:0] FADE_START = 8'd255;
   localparam logic [POT_W-1:0] FADE_STEP  = 8'd5;

   localparam logic [2:0] OP_SET    = 3'd0;
   localparam logic [2:0] OP_UP     = 3'd1;
   localparam logic [2:0] OP_DOWN   = 3'd2;
   localparam logic [2:0] OP_MUTE   = 3'd3;
   localparam logic [2:0] OP_UNMUTE = 3'd4;
   localparam logic [2:0] OP_TOGGLE = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_STEP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIG_STEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_MAX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE_LEVEL  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POT_COMMAND = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic lookup;
      logic emit;
   } vpc_cmd_type;

   typedef struct packed {
      logic noop;
      logic out_free;
      logic last;
   } vpc_sts_type;

   function automatic logic [POT_W-1:0] curve_lookup(input logic [IDX_W-1:0] idx);
      logic [POT_W-1:0] val;
      case (idx)
         5'd0:    val = 8'd255;
         5'd1:    val = 8'd205;
         5'd2:    val = 8'd205;
         5'd3:    val = 8'd205;
         5'd4:    val = 8'd204;
         5'd5:    val = 8'd203;
         5'd6:    val = 8'd201;
         5'd7:    val = 8'd199;
         5'd8:    val = 8'd195;
         5'd9:    val = 8'd190;
         5'd10:   val = 8'd184;
         5'd11:   val = 8'd175;
         5'd12:   val = 8'd165;
         5'd13:   val = 8'd156;
         5'd14:   val = 8'd142;
         5'd15:   val = 8'd126;
         5'd16:   val = 8'd107;
         5'd17:   val = 8'd85;
         5'd18:   val = 8'd60;
         5'd19:   val = 8'd32;
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- sv/volume_pot_controller.sv -----
// Sequence: a request is taken in ST_IDLE, ST_EXEC updates the volume, ST_LOOKUP looks up
// the curve, and each response is registered in ST_EMIT.
// One request at a time; ST_EMIT gives one response per cycle unless the single response
// register is stalled, with up to 51 responses during the startup fade.
// A redundant force or an unknown opcode gives no response.
// Synchronous active-high reset restores the register defaults and the startup state.
module volume_pot_controller import vpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // set_value[6:0], use_small_step[7]
   input  logic [2:0]            req_tuser,  // opcode[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pot_value[7:0], spi_frame[23:8], saved_volume[30:24], saved_mute[31],
   // reported_volume[38:32], zero[39]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,  // pot_write[0], save_write[1]
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   vpc_cmd_type cmd;
   vpc_sts_type sts;

   assign csr_ready = 1'b1;

   vpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   vpc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- sv/vpc_ctrl.sv -----
// Controller state machine of the volume pot controller.
// Depends on vpc_pkg; drives the datapath through vpc_cmd_type and reads vpc_sts_type.
module vpc_ctrl import vpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  vpc_sts_type sts,
   output vpc_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = sts.noop ? ST_IDLE : ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free && sts.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/vpc_dpath.sv -----
// Datapath of the volume pot controller: registers, volume update, curve lookup,
// startup fade and the result register. Depends on vpc_pkg.
module vpc_dpath import vpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast,
   input  vpc_cmd_type           cmd,
   output vpc_sts_type           sts
);

   logic [VOL_W-1:0] small_step_ff, big_step_ff, volume_max_ff, volume_min_ff, mute_level_ff;
   logic [POT_W-1:0] pot_command_ff;

   logic [2:0]       op_ff;
   logic [VOL_W-1:0] set_value_ff;
   logic             small_ff;

   logic [VOL_W-1:0] volume_ff, volume_in;
   logic [VOL_W-1:0] premute_ff, premute_in;
   logic             muted_ff, muted_in;
   logic             starting_up_ff;
   logic [POT_W-1:0] fade_ff;
   logic [POT_W-1:0] target_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                  rsp_last_ff;

   logic [VOL_W-1:0] step, vol_base, set_clamp, set_round;
   logic [VOL_W:0]   up_sum, set_plus;
   logic [15:0]      set_prod;
   logic [IDX_W-1:0] set_quot;
   logic             noop;
   logic [14:0]      vol_prod;
   logic [POT_W-1:0] fade_dec, fade_next;
   logic             res_pw, res_sw, res_last;
   logic [POT_W-1:0] res_pv;
   logic [VOL_W-1:0] res_svol, res_rep;

   always_ff @(posedge clock) begin
      if (reset) begin
         small_step_ff  <= 7'd1;
         big_step_ff    <= 7'd5;
         volume_max_ff  <= VOL_LIMIT;
         volume_min_ff  <= '0;
         mute_level_ff  <= '0;
         pot_command_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SMALL_STEP:  small_step_ff  <= csr_data[VOL_W-1:0];
            CSR_BIG_STEP:    big_step_ff    <= csr_data[VOL_W-1:0];
            CSR_VOLUME_MAX:  volume_max_ff  <= csr_data[VOL_W-1:0];
            CSR_VOLUME_MIN:  volume_min_ff  <= csr_data[VOL_W-1:0];
            CSR_MUTE_LEVEL:  mute_level_ff  <= csr_data[VOL_W-1:0];
            CSR_POT_COMMAND: pot_command_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff        <= req_tuser;
         set_value_ff <= req_tdata[VOL_W-1:0];
         small_ff     <= req_tdata[VOL_W];
      end
   end

   assign step     = small_ff ? small_step_ff : big_step_ff;
   assign vol_base = muted_ff ? premute_ff : volume_ff;
   assign up_sum   = {1'b0, vol_base} + {1'b0, step};
   assign set_clamp = (set_value_ff > VOL_LIMIT) ? VOL_LIMIT : set_value_ff;
   assign set_plus  = {1'b0, set_clamp} + 8'd4;
   assign set_prod  = 16'(set_plus * 8'd205);
   assign set_quot  = set_prod[14:10];
   assign set_round = 7'({set_quot, 2'b00}) + 7'(set_quot);

   assign noop = (op_ff > OP_TOGGLE) || ((op_ff == OP_MUTE) && muted_ff) ||
                 ((op_ff == OP_UNMUTE) && !muted_ff);

   always_comb begin
      volume_in  = volume_ff;
      premute_in = premute_ff;
      muted_in   = muted_ff;
      if (cmd.exec && !noop) begin
         case (op_ff)
            OP_SET: begin
               volume_in = set_round;
            end
            OP_UP: begin
               muted_in  = 1'b0;
               volume_in = (up_sum >= {1'b0, volume_max_ff}) ? volume_max_ff : up_sum[VOL_W-1:0];
            end
            OP_DOWN: begin
               muted_in  = 1'b0;
               volume_in = (vol_base < step) ? volume_min_ff : vol_base - step;
            end
            OP_MUTE, OP_UNMUTE, OP_TOGGLE: begin
               if (muted_ff) begin
                  muted_in  = 1'b0;
                  volume_in = premute_ff;
               end else begin
                  muted_in   = 1'b1;
                  premute_in = volume_ff;
                  volume_in  = mute_level_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign vol_prod = 15'(volume_ff * 8'd205);

   assign fade_dec  = (fade_ff >= FADE_STEP) ? fade_ff - FADE_STEP : '0;
   assign fade_next = (fade_dec < target_ff) ? target_ff : fade_dec;

   always_comb begin
      res_pw   = 1'b1;
      res_sw   = 1'b0;
      res_pv   = target_ff;
      res_last = 1'b1;
      if (starting_up_ff) begin
         if (fade_ff <= target_ff) begin
            res_pw = 1'b0;
            res_pv = '0;
         end else begin
            res_pv   = fade_next;
            res_last = (fade_next == target_ff);
         end
      end else begin
         res_sw = 1'b1;
      end
      res_svol = res_sw ? (muted_ff ? premute_ff : volume_ff) : '0;
      res_rep  = res_last ? volume_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff      <= '0;
         premute_ff     <= '0;
         muted_ff       <= 1'b0;
         starting_up_ff <= 1'b1;
         fade_ff        <= FADE_START;
         rsp_valid_ff   <= 1'b0;
      end else begin
         volume_ff  <= volume_in;
         premute_ff <= premute_in;
         muted_ff   <= muted_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            if (starting_up_ff && res_pw) begin
               fade_ff <= fade_next;
            end
            if (res_last) begin
               starting_up_ff <= 1'b0;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         target_ff <= curve_lookup(vol_prod[14:10]);
      end
      if (cmd.emit) begin
         rsp_data_ff <= {1'b0, res_rep, res_sw & muted_ff, res_svol,
                         res_pw ? pot_command_ff : 8'd0, res_pv, res_pv};
         rsp_user_ff <= {res_sw, res_pw};
         rsp_last_ff <= res_last;
      end
   end

   assign sts.noop     = noop;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign sts.last     = res_last;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- sv/vpc_checker.sv -----
// Port-level checks for the volume pot controller, bound to the top level.
// Depends on vpc_pkg and on the volume_pot_controller ports.
module vpc_checker import vpc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_no_pot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[23:0] == 24'd0)
      else $error("pot fields set without a pot write");

   a_frame_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[15:8] == rsp_tdata[7:0])
      else $error("frame low byte differs from pot value");

   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[38:32] == 7'd0 && !rsp_tuser[1])
      else $error("report or save on a non-final response");

endmodule

bind volume_pot_controller vpc_checker u_vpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
